>>> design/cgst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgst_pkg
// Shared types and constants for the color gradient stop table.
// ----------------------------------------------------------------------------
package cgst_pkg;

    localparam int MaxStopsDefault = 16;
    localparam int CoordW          = 16;
    localparam int ChanW           = 8;
    localparam int ColorW          = 4 * ChanW;

    localparam logic OP_SET    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_LOOKUP   = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_REPLACED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Request to the shared blend unit and its reply.
    typedef struct packed {
        logic              start;
        logic [ColorW-1:0] lo;
        logic [ColorW-1:0] hi;
        logic [CoordW-1:0] n;
        logic [CoordW-1:0] d;
    } blend_req_t;

    typedef struct packed {
        logic              done;
        logic [ColorW-1:0] color;
    } blend_rsp_t;

endpackage

>>> design/cgst_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgst_blend
// Iterative channel blend: one shared multiplier forms lo*(d-n)+hi*n+d/2 for
// each channel, then a shared restoring divider takes one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cgst_blend
    import cgst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  blend_req_t req,
    output blend_rsp_t rsp
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL0 = 4'b0010,
        B_MUL1 = 4'b0100,
        B_DIV  = 4'b1000
    } bstate_t;

    // Accumulator fits in 8+16+1 bits: (d*255 + d/2) < 2^25.
    localparam int AccW = ChanW + CoordW + 1;

    bstate_t           state_reg, state_next;
    logic [1:0]        chan_reg, chan_next;
    logic [4:0]        bit_reg, bit_next;
    logic [AccW-1:0]   acc_reg, acc_next;
    logic [CoordW:0]   rem_reg, rem_next;
    logic [ChanW-1:0]  q_reg, q_next;
    logic [ColorW-1:0] lo_reg, hi_reg, out_reg, out_next;
    logic [CoordW-1:0] n_reg, d_reg;
    logic              done_reg, done_next;

    logic [ChanW-1:0]        mul_a;
    logic [CoordW-1:0]       mul_b;
    logic [ChanW+CoordW-1:0] prod;
    logic [CoordW:0]         trial;

    always_comb begin
        mul_a = (state_reg == B_MUL0) ? lo_reg[chan_reg*ChanW +: ChanW]
                                      : hi_reg[chan_reg*ChanW +: ChanW];
        mul_b = (state_reg == B_MUL0) ? (d_reg - n_reg) : n_reg;
    end
    assign prod  = mul_a * mul_b;
    assign trial = {rem_reg[CoordW-1:0], acc_reg[AccW-1]};

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        bit_next   = bit_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (req.start) begin
                    state_next = B_MUL0;
                    chan_next  = 2'd0;
                end
            end
            B_MUL0: begin
                acc_next   = AccW'(prod) + AccW'(d_reg >> 1);
                state_next = B_MUL1;
            end
            B_MUL1: begin
                acc_next   = acc_reg + AccW'(prod);
                rem_next   = '0;
                bit_next   = 5'(AccW);
                state_next = B_DIV;
            end
            B_DIV: begin
                // restoring step; quotient fits 8 bits, keep low bits
                if (trial >= {1'b0, d_reg}) begin
                    rem_next = trial - {1'b0, d_reg};
                    q_next   = {q_reg[ChanW-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    q_next   = {q_reg[ChanW-2:0], 1'b0};
                end
                acc_next = acc_reg << 1;
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd1) begin
                    out_next[chan_reg*ChanW +: ChanW] = q_next;
                    if (chan_reg == 2'd3) begin
                        state_next = B_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        chan_next  = chan_reg + 2'd1;
                        state_next = B_MUL0;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        chan_reg <= chan_next;
        bit_reg  <= bit_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        out_reg  <= out_next;
        if (state_reg == B_IDLE && req.start) begin
            lo_reg <= req.lo;
            hi_reg <= req.hi;
            n_reg  <= req.n;
            d_reg  <= req.d;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.color = out_reg;

endmodule

>>> design/color_gradient_stop_table.sv
`timescale 1ns / 1ps
// A set scans to its place, then replaces the stop there, is dropped if the
// table is full, or inserts a stop, shifting the entries above up one entry a
// cycle. A lookup scans to its place and, between two stops, has the blend
// unit mix them and waits for its reply. One item at a time; s_ready is low
// while an item is in work or its result waits on m_. Synchronous active-low
// reset empties the table; stop storage itself is not cleared.
// ----------------------------------------------------------------------------
// color_gradient_stop_table
// Sorted color stop table with linear RGBA lookup between stops.
// ----------------------------------------------------------------------------
module color_gradient_stop_table
    import cgst_pkg::*;
#(
    parameter int MAX_STOPS = MaxStopsDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [CoordW-1:0] s_coord,
    input  logic [ChanW-1:0]  s_in_red,
    input  logic [ChanW-1:0]  s_in_green,
    input  logic [ChanW-1:0]  s_in_blue,
    input  logic [ChanW-1:0]  s_in_alpha,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ChanW-1:0]  m_out_red,
    output logic [ChanW-1:0]  m_out_green,
    output logic [ChanW-1:0]  m_out_blue,
    output logic [ChanW-1:0]  m_out_alpha,
    output logic [1:0]        m_status
);

    localparam int IdxW = $clog2(MAX_STOPS);
    localparam int CntW = $clog2(MAX_STOPS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_READ  = 6'b001000,
        S_BLEND = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic [CntW-1:0]   idx_reg, idx_next;
    logic              op_reg;
    logic [CoordW-1:0] coord_reg;
    logic [ColorW-1:0] color_reg;
    logic [ColorW-1:0] res_reg, res_next;
    logic [1:0]        status_reg, status_next;
    logic [CoordW-1:0] prev_pos_reg, prev_pos_next;
    logic [ColorW-1:0] prev_col_reg, prev_col_next;

    // small table held in flops, sequential accesses only
    logic [CoordW-1:0] pos_mem [MAX_STOPS];
    logic [ColorW-1:0] col_mem [MAX_STOPS];
    logic [CoordW-1:0] rd_pos;
    logic [ColorW-1:0] rd_col;
    logic [IdxW-1:0]   rd_addr;

    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    logic [CoordW-1:0] wr_pos;
    logic [ColorW-1:0] wr_col;

    blend_req_t breq;
    blend_rsp_t brsp;

    cgst_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (breq),
        .rsp     (brsp)
    );

    assign rd_addr = idx_reg[IdxW-1:0];
    assign rd_pos  = pos_mem[rd_addr];
    assign rd_col  = col_mem[rd_addr];

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        prev_pos_next = prev_pos_reg;
        prev_col_next = prev_col_reg;
        wr_en         = 1'b0;
        wr_addr       = rd_addr;
        wr_pos        = coord_reg;
        wr_col        = color_reg;
        breq          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    idx_next   = '0;
                    res_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // walk entries until the first position >= coord
                if (idx_reg < count_reg && rd_pos < coord_reg) begin
                    prev_pos_next = rd_pos;
                    prev_col_next = rd_col;
                    idx_next      = idx_reg + 1'b1;
                end else if (op_reg == OP_SET) begin
                    if (idx_reg < count_reg && rd_pos == coord_reg) begin
                        wr_en       = 1'b1;
                        status_next = ST_REPLACED;
                        state_next  = S_OUT;
                    end else if (count_reg == CntW'(MAX_STOPS)) begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end else begin
                        status_next = ST_INSERTED;
                        idx_next    = count_reg;
                        count_next  = count_reg + 1'b1;
                        state_next  = S_SHIFT;
                        prev_pos_next = {CoordW{1'b0}};
                        // the insertion point is kept in prev_col low bits;
                        // S_SHIFT compares idx against it to stop the shift
                        prev_col_next = ColorW'(idx_reg);
                    end
                end else begin
                    status_next = ST_LOOKUP;
                    if (count_reg == '0) begin
                        state_next = S_OUT;
                    end else if (idx_reg == '0) begin
                        res_next   = rd_col;   // at or below first stop
                        state_next = S_OUT;
                    end else if (idx_reg == count_reg) begin
                        res_next   = prev_col_reg; // beyond last stop
                        state_next = S_OUT;
                    end else if (rd_pos == coord_reg) begin
                        res_next   = rd_col;   // exactly on a stop: n = d
                        state_next = S_OUT;
                    end else begin
                        state_next = S_BLEND;
                        breq.start = 1'b1;
                        breq.lo    = prev_col_reg;
                        breq.hi    = rd_col;
                        breq.n     = coord_reg - prev_pos_reg;
                        breq.d     = rd_pos - prev_pos_reg;
                    end
                end
            end
            S_SHIFT: begin
                // move entry idx-1 up one place, down to the insertion point
                wr_en = 1'b1;
                if (idx_reg == CntW'(prev_col_reg)) begin
                    state_next = S_OUT;
                end else begin
                    wr_pos   = pos_mem[IdxW'(idx_reg - 1'b1)];
                    wr_col   = col_mem[IdxW'(idx_reg - 1'b1)];
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_READ: state_next = S_BLEND;
            S_BLEND: begin
                if (brsp.done) begin
                    res_next   = brsp.color;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg      <= idx_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        prev_pos_reg <= prev_pos_next;
        prev_col_reg <= prev_col_next;
        if (state_reg == S_IDLE && s_valid) begin
            op_reg    <= s_opcode;
            coord_reg <= s_coord;
            color_reg <= {s_in_alpha, s_in_blue, s_in_green, s_in_red};
        end
        if (wr_en) begin
            pos_mem[wr_addr] <= wr_pos;
            col_mem[wr_addr] <= wr_col;
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = (state_reg == S_OUT);
    assign m_out_red   = res_reg[0*ChanW +: ChanW];
    assign m_out_green = res_reg[1*ChanW +: ChanW];
    assign m_out_blue  = res_reg[2*ChanW +: ChanW];
    assign m_out_alpha = res_reg[3*ChanW +: ChanW];
    assign m_status    = status_reg;

endmodule

>>> design/cgst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgst_checker
// Port-level checks for the color gradient stop table.
// ----------------------------------------------------------------------------
module cgst_checker
    import cgst_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [ChanW-1:0] m_out_red,
    input logic [ChanW-1:0] m_out_green,
    input logic [ChanW-1:0] m_out_blue,
    input logic [ChanW-1:0] m_out_alpha,
    input logic [1:0]       m_status
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");

    a_set_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_LOOKUP) |->
        (m_out_red == '0 && m_out_green == '0 && m_out_blue == '0 && m_out_alpha == '0))
        else $error("set result carries color");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result dropped while stalled");

endmodule

bind color_gradient_stop_table cgst_checker u_cgst_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_red   (m_out_red),
    .m_out_green (m_out_green),
    .m_out_blue  (m_out_blue),
    .m_out_alpha (m_out_alpha),
    .m_status    (m_status)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the color gradient stop table: drives set and
// lookup transfers with random gaps and stalls, predicts each result from a
// private copy of the stop table, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
    import cgst_pkg::*;

    localparam int MaxStops = MaxStopsDefault;

    typedef struct packed {
        logic [7:0] red, green, blue, alpha;
        logic [1:0] status;
    } gradient_result_t;

    class gradient_scoreboard;
        logic [15:0] position[MaxStops];
        logic [31:0] color[MaxStops];
        int count;
        gradient_result_t pending[$];
        int mismatches;
        int checked;
        int inserts, replaces, drops, lookups;

        function void clear_table();
            count = 0;
        endfunction

        function logic [7:0] mix(logic [7:0] lo, logic [7:0] hi, int n, int d);
            longint acc;
            acc = longint'(lo) * (d - n) + longint'(hi) * n + d / 2;
            return 8'(acc / d);
        endfunction

        function void note_input(logic op, logic [15:0] coord, logic [31:0] c);
            gradient_result_t r;
            int i, n, d;
            r = '{default: '0};
            if (op == OP_SET) begin
                i = 0;
                while (i < count && position[i] < coord) i++;
                if (i < count && position[i] == coord) begin
                    color[i] = c;
                    r.status = ST_REPLACED;
                    replaces++;
                end else if (count >= MaxStops) begin
                    r.status = ST_FULL;
                    drops++;
                end else begin
                    for (int k = count; k > i; k--) begin
                        position[k] = position[k-1];
                        color[k] = color[k-1];
                    end
                    position[i] = coord;
                    color[i] = c;
                    count++;
                    r.status = ST_INSERTED;
                    inserts++;
                end
            end else begin
                r.status = ST_LOOKUP;
                lookups++;
                if (count > 0) begin
                    logic [31:0] out;
                    if (count == 1 || coord <= position[0]) out = color[0];
                    else if (coord >= position[count-1]) out = color[count-1];
                    else begin
                        i = 0;
                        while (i + 1 < count - 1 && position[i+1] <= coord) i++;
                        d = position[i+1] - position[i];
                        n = coord - position[i];
                        for (int k = 0; k < 4; k++)
                            out[8*k +: 8] = mix(color[i][8*k +: 8],
                                                color[i+1][8*k +: 8], n, d);
                    end
                    {r.alpha, r.blue, r.green, r.red} = out;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(gradient_result_t got);
            gradient_result_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status=%0d", got.status);
                return;
            end
            want = pending.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp rgba=%h %h %h %h st=%0d got %h %h %h %h st=%0d",
                             want.red, want.green, want.blue, want.alpha, want.status,
                             got.red, got.green, got.blue, got.alpha, got.status);
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, s_opcode;
    logic [15:0] s_coord;
    logic [7:0] s_in_red, s_in_green, s_in_blue, s_in_alpha;
    logic m_valid, m_ready;
    logic [7:0] m_out_red, m_out_green, m_out_blue, m_out_alpha;
    logic [1:0] m_status;

    gradient_scoreboard board;
    bit hold_off;
    int idle_cycles;
    logic [15:0] used_coords[$];

    color_gradient_stop_table #(.MAX_STOPS(MaxStops)) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Keep valid high across back-to-back items; drop it only for a gap.
    task automatic send_item(logic op, logic [15:0] coord, logic [31:0] c);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_coord <= coord;
        {s_in_alpha, s_in_blue, s_in_green, s_in_red} <= c;
        do @(posedge aclk); while (!s_ready);
        board.note_input(op, coord, c);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return used_coords.size() ? used_coords[$urandom_range(0, used_coords.size()-1)]
                                         : 16'($urandom);
            3: return used_coords.size() ?
                      16'(used_coords[$urandom_range(0, used_coords.size()-1)]
                          + $urandom_range(0, 2) - 1) : 16'($urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: a drawn wait before each transfer, plus one long hold-off.
    initial begin
        int wait_cycles;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            wait_cycles = $urandom_range(0, 10);
            if (hold_off) begin
                wait_cycles = 300;
                hold_off = 1'b0;
            end
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_result('{m_out_red, m_out_green, m_out_blue,
                                 m_out_alpha, m_status});
        end
    end

    initial begin
        board = new();
        board.clear_table();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_SET;
        s_coord = '0;
        {s_in_alpha, s_in_blue, s_in_green, s_in_red} = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty lookup, single stop, ends, replace, interpolation.
        send_item(OP_LOOKUP, 16'h8000, 32'hFFFF_FFFF);
        send_item(OP_SET, 16'h4000, 32'hFF00_FF00);
        send_item(OP_LOOKUP, 16'h0000, 32'h0);
        send_item(OP_LOOKUP, 16'hFFFF, 32'h0);
        send_item(OP_SET, 16'h4000, 32'h00FF_00FF);
        send_item(OP_SET, 16'h0000, 32'h0000_0000);
        send_item(OP_SET, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 16'h0000, 32'h0);
        send_item(OP_LOOKUP, 16'hFFFF, 32'h0);
        send_item(OP_LOOKUP, 16'h2000, 32'h0);
        send_item(OP_LOOKUP, 16'h4000, 32'h0);
        send_item(OP_LOOKUP, 16'hA000, 32'h0);
        send_item(OP_LOOKUP, 16'h0001, 32'h0);
        for (int k = 1; k <= 14; k++)
            send_item(OP_SET, 16'(k * 4096 + 1), $urandom);
        send_item(OP_SET, 16'h1234, 32'hDEAD_BEEF);        // full, dropped
        send_item(OP_SET, 16'hFFFF, 32'h1234_5678);        // full but replaced
        wait_drained();

        // Long receiver stall while offering items.
        hold_off = 1'b1;
        for (int k = 0; k < 6; k++) send_item(OP_LOOKUP, 16'($urandom), 32'h0);

        // Random items; the table is never emptied by reset, so it stays full from
        // the directed part and lookups dominate.
        for (int k = 0; k < 1420; k++) begin
            logic op;
            logic [15:0] c;
            op = ($urandom_range(0, 2) != 0) ? OP_LOOKUP : OP_SET;
            c = pick_coord();
            if (op == OP_SET) used_coords.push_back(c);
            send_item(op, c, $urandom);
        end
        wait_drained();
        repeat (200) @(posedge aclk);

        $display("Covered %0d inserts, %0d replaces, %0d dropped sets, %0d lookups.",
                 board.inserts, board.replaces, board.drops, board.lookups);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
